@@ sv/jas_pkg.sv @@
`default_nettype none

package jas_pkg;

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_APP1   = 8'hE1;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_EOI    = 8'hD9;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_STRIP_ENABLE = 3'd0;

   typedef enum logic [3:0] {
      MODE_FIRST  = 4'd0,
      MODE_SECOND = 4'd1,
      MODE_PASS   = 4'd2,
      MODE_SCAN   = 4'd3,
      MODE_MARKER = 4'd4,
      MODE_LENHI  = 4'd5,
      MODE_LENLO  = 4'd6,
      MODE_BODY   = 4'd7
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_end;
      logic       stream_end;
   } rsp_type;

   // results produced by one input transaction
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

@@ sv/jas_csr.sv @@
`default_nettype none

module jas_csr
   import jas_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic      [31:0]       csr_prdata,
   output logic                   csr_pready,
   output logic                   strip_enable
);

   logic strip_enable_ff;
   logic strip_enable_in;
   logic wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_STRIP_ENABLE);
   assign csr_pready = 1'b1;

   always_comb begin
      strip_enable_in = strip_enable_ff;
      if (wr_en) begin
         strip_enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_enable_ff <= 1'b1;
      end else begin
         strip_enable_ff <= strip_enable_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == CSR_STRIP_ENABLE) begin
         csr_prdata = {31'd0, strip_enable_ff};
      end
   end

   assign strip_enable = strip_enable_ff;

endmodule

`default_nettype wire

@@ sv/jas_parser.sv @@
`default_nettype none

module jas_parser
   import jas_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     strip_enable,
   input  wire logic     accept,
   input  wire req_type  req,
   output push_type      push
);

   mode_type    mode_ff, mode_in;
   logic        first_ff_ff, first_ff_in;
   logic        drop_ff, drop_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] remain_ff, remain_in;

   logic [7:0]  b;
   logic [15:0] len;
   logic [15:0] remain_dec;
   logic [1:0]  n;
   logic [7:0]  byte0, byte1;

   assign b          = req.in_byte;
   assign len        = {len_hi_ff, b};
   assign remain_dec = remain_ff - 16'd1;

   always_comb begin
      mode_in     = mode_ff;
      first_ff_in = first_ff_ff;
      drop_in     = drop_ff;
      len_hi_in   = len_hi_ff;
      remain_in   = remain_ff;
      n           = 2'd0;
      byte0       = b;
      byte1       = b;

      unique case (mode_ff)
         MODE_FIRST: begin
            if (strip_enable && b == MARK_PREFIX) begin
               first_ff_in = 1'b1;
               mode_in     = MODE_SECOND;
               if (req.in_last) begin
                  n = 2'd1;
               end
            end else begin
               n       = 2'd1;
               mode_in = MODE_PASS;
            end
         end
         MODE_SECOND: begin
            n       = 2'd2;
            byte0   = MARK_PREFIX;
            mode_in = (b == MARK_SOI) ? MODE_SCAN : MODE_PASS;
         end
         MODE_SCAN: begin
            if (b == MARK_PREFIX) begin
               mode_in = MODE_MARKER;
               if (req.in_last) begin
                  n = 2'd1;
               end
            end else begin
               n = 2'd1;
            end
         end
         MODE_MARKER: begin
            if (b == MARK_APP1) begin
               drop_in = 1'b1;
               mode_in = MODE_LENHI;
            end else begin
               n     = 2'd2;
               byte0 = MARK_PREFIX;
               if (b == MARK_SOS) begin
                  mode_in = MODE_PASS;
               end else if (b == MARK_EOI) begin
                  mode_in = MODE_SCAN;
               end else begin
                  drop_in = 1'b0;
                  mode_in = MODE_LENHI;
               end
            end
         end
         MODE_LENHI: begin
            len_hi_in = b;
            n         = drop_ff ? 2'd0 : 2'd1;
            mode_in   = MODE_LENLO;
         end
         MODE_LENLO: begin
            remain_in = (len < 16'd2) ? 16'd0 : len - 16'd2;
            n         = drop_ff ? 2'd0 : 2'd1;
            mode_in   = (len > 16'd2) ? MODE_BODY : MODE_SCAN;
         end
         MODE_BODY: begin
            n         = drop_ff ? 2'd0 : 2'd1;
            remain_in = remain_dec;
            if (remain_dec == 16'd0) begin
               mode_in = MODE_SCAN;
            end
         end
         default: begin
            n = 2'd1;
         end
      endcase

      if (req.in_last) begin
         mode_in     = MODE_FIRST;
         first_ff_in = 1'b0;
         drop_in     = 1'b0;
         len_hi_in   = 8'd0;
         remain_in   = 16'd0;
      end
   end

   // build result words; end-only result when the final byte emits nothing
   always_comb begin
      push.first  = '0;
      push.second = '0;
      if (n == 2'd0) begin
         push.count             = req.in_last ? 2'd1 : 2'd0;
         push.first.run_end     = 1'b1;
         push.first.stream_end  = 1'b1;
      end else begin
         push.count             = n;
         push.first.out_byte    = byte0;
         push.first.byte_valid  = 1'b1;
         push.second.out_byte   = byte1;
         push.second.byte_valid = 1'b1;
         if (n == 2'd1) begin
            push.first.run_end    = 1'b1;
            push.first.stream_end = req.in_last;
         end else begin
            push.second.run_end    = 1'b1;
            push.second.stream_end = req.in_last;
         end
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_FIRST;
         first_ff_ff <= 1'b0;
         drop_ff     <= 1'b0;
         len_hi_ff   <= 8'd0;
         remain_ff   <= 16'd0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         first_ff_ff <= first_ff_in;
         drop_ff     <= drop_in;
         len_hi_ff   <= len_hi_in;
         remain_ff   <= remain_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/jas_out_fifo.sv @@
`default_nettype none

module jas_out_fifo
   import jas_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   rsp_type              mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;
   logic [FIFO_AW-1:0]   wr_ptr_next;

   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push.count) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_next] <= push.second;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem[rd_ptr_ff];
   assign room        = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

@@ sv/jpeg_app1_segment_stripper.sv @@
// JPEG APP1 segment stripper. Takes one file byte per transaction on req_ and
// gives the filtered stream on rsp_, one result per transaction; a file is
// parsed only when strip_enable is set and it opens with FF D8. A byte is taken
// every cycle while the four-entry result queue has room for two results;
// an FF held back for one byte and released together with the next gives two
// results from one input, so the sustained rate is one byte per cycle,
// bounded by the rsp_ side at one result per cycle. An accepted byte's results
// are written into the result queue, whose count register drives rsp_valid.
// strip_enable, at address 0, is sampled at the first byte of each file.
`default_nettype none

module jpeg_app1_segment_stripper
   import jas_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_payload,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic      [31:0]       csr_prdata,
   output logic                   csr_pready
);

   logic     strip_enable;
   logic     room;
   logic     accept;
   push_type push;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   jas_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .strip_enable (strip_enable)
   );

   jas_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .strip_enable (strip_enable),
      .accept       (accept),
      .req          (req_payload),
      .push         (push)
   );

   jas_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ verif/jpeg_app1_segment_stripper_test.sv @@
`default_nettype none

module jpeg_app1_segment_stripper_test
   import jas_pkg::*;
();

   localparam logic [7:0] MARK_SOF0 = 8'hC0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   jpeg_app1_segment_stripper DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stripper state as the block should hold it
   logic        strip_en_m = 1'b1;
   mode_type    mode_m = MODE_FIRST;
   logic        dropping_m = 1'b0;
   logic [7:0]  len_hi_m = '0;
   logic [15:0] body_left_m = '0;

   rsp_type     stripped_q[$];
   logic [7:0]  file_q[$];
   rsp_type     want_head;

   int          errors = 0;
   int          bytes_sent = 0;
   int          files_sent = 0;
   int          outputs_checked = 0;
   int          burst_left = 0;
   logic        steady = 1'b0;

   int          stall_pct = 0;
   int          rx_cycle = 0;
   int          hold_len = 0;
   logic        hold_req = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   function automatic rsp_type data_out(input logic [7:0] b);
      return '{out_byte: b, byte_valid: 1'b1, run_end: 1'b0, stream_end: 1'b0};
   endfunction

   task automatic strip_byte(input req_type r);
      rsp_type     outs[$];
      rsp_type     tail;
      rsp_type     blank;
      logic [15:0] seg_len;
      logic [7:0]  b;
      b = r.in_byte;
      blank = '0;
      case (mode_m)
         MODE_FIRST: begin
            if (strip_en_m && b == MARK_PREFIX) begin
               mode_m = MODE_SECOND;
               if (r.in_last) outs.insert(outs.size(), data_out(b));
            end else begin
               outs.insert(outs.size(), data_out(b));
               mode_m = MODE_PASS;
            end
         end
         MODE_SECOND: begin
            outs.insert(outs.size(), data_out(MARK_PREFIX));
            outs.insert(outs.size(), data_out(b));
            mode_m = (b == MARK_SOI) ? MODE_SCAN : MODE_PASS;
         end
         MODE_SCAN: begin
            if (b == MARK_PREFIX) begin
               mode_m = MODE_MARKER;
               if (r.in_last) outs.insert(outs.size(), data_out(b));
            end else begin
               outs.insert(outs.size(), data_out(b));
            end
         end
         MODE_MARKER: begin
            if (b == MARK_APP1) begin
               dropping_m = 1'b1;
               mode_m = MODE_LENHI;
            end else begin
               outs.insert(outs.size(), data_out(MARK_PREFIX));
               outs.insert(outs.size(), data_out(b));
               if (b == MARK_SOS) begin
                  mode_m = MODE_PASS;
               end else if (b == MARK_EOI) begin
                  mode_m = MODE_SCAN;
               end else begin
                  dropping_m = 1'b0;
                  mode_m = MODE_LENHI;
               end
            end
         end
         MODE_LENHI: begin
            len_hi_m = b;
            if (!dropping_m) outs.insert(outs.size(), data_out(b));
            mode_m = MODE_LENLO;
         end
         MODE_LENLO: begin
            seg_len = {len_hi_m, b};
            if (seg_len < 16'd2) seg_len = 16'd2;
            body_left_m = seg_len - 16'd2;
            if (!dropping_m) outs.insert(outs.size(), data_out(b));
            mode_m = (body_left_m != 16'd0) ? MODE_BODY : MODE_SCAN;
         end
         MODE_BODY: begin
            if (!dropping_m) outs.insert(outs.size(), data_out(b));
            body_left_m = body_left_m - 16'd1;
            if (body_left_m == 16'd0) mode_m = MODE_SCAN;
         end
         default: begin
            outs.insert(outs.size(), data_out(b));
         end
      endcase

      if (r.in_last && outs.size() == 0) outs.insert(0, blank);
      if (outs.size() > 0) begin
         tail = outs[outs.size() - 1];
         tail.run_end = 1'b1;
         tail.stream_end = r.in_last;
         outs[outs.size() - 1] = tail;
      end
      if (r.in_last) begin
         mode_m = MODE_FIRST;
         dropping_m = 1'b0;
         len_hi_m = '0;
         body_left_m = '0;
      end
      foreach (outs[i]) stripped_q.insert(stripped_q.size(), outs[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_type r;
      int      gap;
      r.in_byte = b;
      r.in_last = fin;
      @(negedge clock);
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      strip_byte(r);
      bytes_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_file();
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
      files_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (stripped_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_strip(input logic en);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_STRIP_ENABLE;
      csr_pwdata <= {31'd0, en};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      strip_en_m = en;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== en) begin
         errors++;
         $display("%0t: strip_enable readback expected %b got %b", $time, en, csr_prdata[0]);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic build_jpeg(input logic wild);
      int          pick;
      int          body;
      logic [7:0]  mk;
      logic [15:0] seg_len;
      file_q = '{MARK_PREFIX, MARK_SOI};
      repeat ($urandom_range(1, 5)) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            repeat ($urandom_range(1, 3))
               file_q.insert(file_q.size(), 8'($urandom_range(0, 254)));
         end else if (pick < 25) begin
            file_q.insert(file_q.size(), MARK_PREFIX);
            file_q.insert(file_q.size(), MARK_EOI);
         end else begin
            if (pick < 60) begin
               mk = MARK_APP1;
            end else begin
               do mk = 8'($urandom_range(0, 255));
               while (mk == MARK_APP1 || mk == MARK_SOS || mk == MARK_EOI);
            end
            pick = $urandom_range(0, 99);
            if (wild) seg_len = 16'($urandom_range(0, 65535));
            else if (pick < 10) seg_len = 16'($urandom_range(0, 1));
            else if (pick < 95) seg_len = 16'($urandom_range(2, 10));
            else seg_len = 16'($urandom_range(11, 300));
            file_q.insert(file_q.size(), MARK_PREFIX);
            file_q.insert(file_q.size(), mk);
            file_q.insert(file_q.size(), seg_len[15:8]);
            file_q.insert(file_q.size(), seg_len[7:0]);
            body = (seg_len < 16'd2) ? 0 : int'(seg_len) - 2;
            if (wild && body > 24) body = 24;
            repeat (body) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         file_q.insert(file_q.size(), MARK_PREFIX);
         file_q.insert(file_q.size(), MARK_SOS);
         repeat ($urandom_range(0, 6)) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
         file_q.insert(file_q.size(), MARK_PREFIX);
         file_q.insert(file_q.size(), MARK_EOI);
      end else if (pick < 85) begin
         file_q.insert(file_q.size(), MARK_PREFIX);
      end else begin
         file_q.insert(file_q.size(), 8'($urandom_range(0, 254)));
      end
   endtask

   task automatic build_noise();
      file_q = '{};
      if ($urandom_range(0, 2) == 0) file_q.insert(file_q.size(), MARK_PREFIX);
      repeat ($urandom_range(1, 12)) file_q.insert(file_q.size(), 8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed_jpeg();
      set_strip(1'b1);
      file_q = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1, 8'h00, 8'h03, 8'h55,
                 MARK_PREFIX, MARK_SOF0, 8'h00, 8'h03, 8'hFF, MARK_PREFIX, MARK_EOI,
                 MARK_PREFIX, MARK_SOS, 8'hFF, 8'h00};
      send_file();
      file_q = '{MARK_PREFIX};
      send_file();
      // zero length APP1, then the file ends inside a dropped segment
      file_q = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1, 8'h00, 8'h00,
                 MARK_PREFIX, MARK_APP1, 8'h00, 8'h03, 8'h00};
      send_file();
      // fill marker with short length, then a held FF as the final byte
      file_q = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_PREFIX, 8'h00, 8'h01, MARK_PREFIX};
      send_file();
      drain();
   endtask

   task automatic test_plain_files();
      file_q = '{MARK_PREFIX, 8'h00, MARK_PREFIX, MARK_APP1};
      send_file();
      file_q = '{MARK_SOI, MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1};
      send_file();
      drain();
   endtask

   task automatic test_strip_disabled();
      set_strip(1'b0);
      file_q = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1, 8'h00, 8'h02, MARK_PREFIX};
      send_file();
      drain();
      set_strip(1'b1);
   endtask

   task automatic test_backpressure();
      int start;
      steady = 1'b1;
      hold_len = 120;
      hold_req = ~hold_req;
      start = bytes_sent;
      while (bytes_sent - start < 40) begin
         build_jpeg(1'b0);
         send_file();
      end
      steady = 1'b0;
      drain();
   endtask

   task automatic test_random_files(input logic en, input int count);
      int start;
      int pick;
      int cut;
      set_strip(en);
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         pick = $urandom_range(0, 99);
         steady = ($urandom_range(0, 9) == 0);
         if (pick < 60) begin
            build_jpeg(1'b0);
         end else if (pick < 80) begin
            build_jpeg(1'b1);
            cut = $urandom_range(1, file_q.size());
            file_q = file_q[0:cut-1];
         end else begin
            build_noise();
         end
         send_file();
      end
      steady = 1'b0;
      drain();
   endtask

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 150 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stripped_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none got %h/%b/%b/%b", $time,
                     rsp_payload.out_byte, rsp_payload.byte_valid, rsp_payload.run_end,
                     rsp_payload.stream_end);
         end else begin
            want_head = stripped_q.pop_front();
            outputs_checked++;
            check_field("out_byte", want_head.out_byte, rsp_payload.out_byte);
            check_field("byte_valid", 8'(want_head.byte_valid), 8'(rsp_payload.byte_valid));
            check_field("run_end", 8'(want_head.run_end), 8'(rsp_payload.run_end));
            check_field("stream_end", 8'(want_head.stream_end), 8'(rsp_payload.stream_end));
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_jpeg();
      test_plain_files();
      test_strip_disabled();
      test_backpressure();
      test_random_files(1'b1, 450);
      test_random_files(1'b0, 150);
      test_random_files(1'b1, 150);
      drain();
      $display("Streamed %0d bytes in %0d files, stripping on and off, under output holds",
               bytes_sent, files_sent);
      $display("%0d output transactions checked", outputs_checked);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(20 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
